[hw/rtl/vwap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwap_pkg
// Shared widths, register codes and sequencer states of the VWAP block.
// ----------------------------------------------------------------------------
package vwap_pkg;

  localparam int unsigned TS_W      = 40;
  localparam int unsigned PRICE_W   = 20;
  localparam int unsigned VOL_W     = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned VAL_W     = 28;
  localparam int unsigned BAND_W    = 31;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned MAX_BANDS = 3;
  localparam int unsigned PER_W     = 32;
  localparam int unsigned OFS_W     = 17;
  localparam int unsigned CNT_W     = 2;

  // dividend of the shared divider: accumulator with the wider fraction appended
  localparam int unsigned DVD_W     = ACC_W + 2 * FRAC_W;
  localparam int unsigned ROOT_W    = ACC_W / 2;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W   = 2 * PRICE_W;
  localparam int unsigned MUL_B_W   = VAL_W;

  localparam logic [PER_W-1:0] DAY_SECONDS = PER_W'(86400);
  localparam logic [VAL_W-1:0] VAL_MAX     = {VAL_W{1'b1}};

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_FILTER   = 3'd1,
    REG_OFFSET   = 3'd2,
    REG_DURATION = 3'd3,
    REG_BANDS    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_TS_DIV,
    S_MUL_PP,
    S_MUL_PPV,
    S_ACC_SQ,
    S_DIV_V,
    S_DIV_M,
    S_MUL_VV,
    S_SQRT_GO,
    S_SQRT,
    S_OUT
  } state_e;

endpackage

[hw/rtl/vwap_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwap interfaces
// Trade request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vwap_in_if;
  logic                         valid;
  logic                         ready;
  logic [vwap_pkg::TS_W-1:0]    timestamp;
  logic [vwap_pkg::PRICE_W-1:0] price;
  logic [vwap_pkg::VOL_W-1:0]   volume;

  modport source (output valid, timestamp, price, volume, input ready);
  modport sink   (input valid, timestamp, price, volume, output ready);
endinterface

interface vwap_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic                              new_period;
  logic        [vwap_pkg::VAL_W-1:0]  vwap;
  logic        [vwap_pkg::VAL_W-1:0]  std_dev;
  logic signed [vwap_pkg::BAND_W-1:0] band1_low;
  logic signed [vwap_pkg::BAND_W-1:0] band1_high;
  logic signed [vwap_pkg::BAND_W-1:0] band2_low;
  logic signed [vwap_pkg::BAND_W-1:0] band2_high;
  logic signed [vwap_pkg::BAND_W-1:0] band3_low;
  logic signed [vwap_pkg::BAND_W-1:0] band3_high;
  logic                              overflow;
  logic                              zero_volume;

  modport source (output valid, accepted, new_period, vwap, std_dev, band1_low, band1_high,
                  band2_low, band2_high, band3_low, band3_high, overflow, zero_volume,
                  input ready);
  modport sink   (input valid, accepted, new_period, vwap, std_dev, band1_low, band1_high,
                  band2_low, band2_high, band3_low, band3_high, overflow, zero_volume,
                  output ready);
endinterface

[hw/rtl/vwap_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwap_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module vwap_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vwap_pkg::DVD_W-1:0]  dividend_i,
  input  logic [vwap_pkg::ACC_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [vwap_pkg::DVD_W-1:0]  quot_o,
  output logic [vwap_pkg::ACC_W-1:0]  rem_o
);

  localparam int unsigned STEP_W = $clog2(vwap_pkg::DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(vwap_pkg::DVD_W - 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [STEP_W-1:0]          cnt_q, cnt_d;
  logic [vwap_pkg::DVD_W-1:0] dvd_q, dvd_d;
  logic [vwap_pkg::ACC_W-1:0] rem_q, rem_d;
  logic [vwap_pkg::ACC_W-1:0] den_q, den_d;
  logic [vwap_pkg::ACC_W:0]   trial;
  logic [vwap_pkg::ACC_W:0]   diff;
  logic                       ge;

  always_comb begin
    trial  = {rem_q, dvd_q[vwap_pkg::DVD_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[vwap_pkg::DVD_W-2:0], ge};
      rem_d = ge ? diff[vwap_pkg::ACC_W-1:0] : trial[vwap_pkg::ACC_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/vwap_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwap_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vwap_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vwap_pkg::ACC_W-1:0]  value_i,
  output logic                        done_o,
  output logic [vwap_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned STEP_W = $clog2(vwap_pkg::ROOT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(vwap_pkg::ROOT_W - 1);
  localparam logic [vwap_pkg::ACC_W-1:0] TOP_BIT =
    {2'b01, {(vwap_pkg::ACC_W-2){1'b0}}};

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [STEP_W-1:0]          cnt_q, cnt_d;
  logic [vwap_pkg::ACC_W-1:0] v_q, v_d;
  logic [vwap_pkg::ACC_W-1:0] res_q, res_d;
  logic [vwap_pkg::ACC_W-1:0] bit_q, bit_d;
  logic [vwap_pkg::ACC_W-1:0] sum;
  logic                       ge;

  always_comb begin
    sum    = res_q + bit_q;
    ge     = v_q >= sum;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      v_d    = value_i;
      res_d  = '0;
      bit_d  = TOP_BIT;
    end else if (busy_q) begin
      v_d   = ge ? v_q - sum : v_q;
      res_d = ge ? (res_q >> 1) + bit_q : res_q >> 1;
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[vwap_pkg::ROOT_W-1:0];

endmodule

[hw/rtl/vwap_with_deviation_bands.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwap_with_deviation_bands
// Per-period VWAP with standard deviation and up to three band pairs.
// ----------------------------------------------------------------------------
// One trade request at a time; ready is high only while the sequencer is idle.
// The shared restoring divider runs 80 single-bit steps for the timestamp
// split, then, for an accepted trade with non-zero summed volume, again for
// the VWAP and again for the second moment; the square root then takes 32
// steps, and the shared multiplier and the sums do the rest. The result sits
// in an output register, so the next trade is taken while it waits. The user
// writes configuration through the APB port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module vwap_with_deviation_bands (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vwap_in_if.sink                       in_i,
  vwap_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vwap_pkg::APB_AW-1:0]   paddr,
  input  logic [vwap_pkg::APB_DW-1:0]   pwdata,
  output logic [vwap_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned ACC_W = vwap_pkg::ACC_W;
  localparam int unsigned TS_W  = vwap_pkg::TS_W;
  localparam int unsigned VAL_W = vwap_pkg::VAL_W;
  localparam int unsigned BW    = vwap_pkg::BAND_W;
  localparam int unsigned PER_W = vwap_pkg::PER_W;
  localparam int unsigned OFS_W = vwap_pkg::OFS_W;
  localparam int unsigned OPN_W = TS_W + 1;
  localparam int unsigned MUL_W = vwap_pkg::MUL_A_W + vwap_pkg::MUL_B_W;

  // ---- configuration registers ---------------------------------------------
  logic [PER_W-1:0]           period_q;
  logic                       filter_q;
  logic [OFS_W-1:0]           offset_q;
  logic [OFS_W-1:0]           duration_q;
  logic [vwap_pkg::CNT_W-1:0] bands_q;
  logic                       wr_en;
  vwap_pkg::cfg_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = vwap_pkg::cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= vwap_pkg::DAY_SECONDS;
      filter_q   <= 1'b0;
      offset_q   <= '0;
      duration_q <= '0;
      bands_q    <= vwap_pkg::CNT_W'(vwap_pkg::MAX_BANDS);
    end else if (wr_en) begin
      case (reg_sel)
        vwap_pkg::REG_PERIOD:   period_q   <= pwdata[PER_W-1:0];
        vwap_pkg::REG_FILTER:   filter_q   <= pwdata[0];
        vwap_pkg::REG_OFFSET:   offset_q   <= pwdata[OFS_W-1:0];
        vwap_pkg::REG_DURATION: duration_q <= pwdata[OFS_W-1:0];
        vwap_pkg::REG_BANDS:    bands_q    <= pwdata[vwap_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      vwap_pkg::REG_PERIOD:   prdata = period_q;
      vwap_pkg::REG_FILTER:   prdata = {{(vwap_pkg::APB_DW-1){1'b0}}, filter_q};
      vwap_pkg::REG_OFFSET:   prdata = {{(vwap_pkg::APB_DW-OFS_W){1'b0}}, offset_q};
      vwap_pkg::REG_DURATION: prdata = {{(vwap_pkg::APB_DW-OFS_W){1'b0}}, duration_q};
      vwap_pkg::REG_BANDS:    prdata = {{(vwap_pkg::APB_DW-vwap_pkg::CNT_W){1'b0}}, bands_q};
      default:                prdata = '0;
    endcase
  end

  // ---- derived configuration ----------------------------------------------
  logic [PER_W-1:0] per_eff;
  logic             daily;
  logic [PER_W:0]   dur_eff;

  assign per_eff = (period_q != '0) ? period_q : PER_W'(1);
  assign daily   = filter_q && (per_eff == vwap_pkg::DAY_SECONDS);
  assign dur_eff = (duration_q != '0) ? {{(PER_W+1-OFS_W){1'b0}}, duration_q}
                                      : {1'b0, per_eff};

  // ---- state ------------------------------------------------------------------
  vwap_pkg::state_e state_q, state_d;

  logic [TS_W-1:0]              ts_q, ts_d;
  logic [vwap_pkg::PRICE_W-1:0] price_q, price_d;
  logic [vwap_pkg::VOL_W-1:0]   vol_q, vol_d;
  logic                         active_q, active_d;
  logic [OPN_W-1:0]             open_q, open_d;
  logic [ACC_W-1:0]             spv_q, spv_d;
  logic [ACC_W-1:0]             sv_q, sv_d;
  logic [ACC_W-1:0]             spsv_q, spsv_d;
  logic [VAL_W-1:0]             hvwap_q, hvwap_d;
  logic [VAL_W-1:0]             hdev_q, hdev_d;
  logic                         ovf_q, ovf_d;
  logic                         acc_q, acc_d;
  logic                         newp_q, newp_d;
  logic [ACC_W-1:0]             prod_q, prod_d;
  logic [VAL_W-1:0]             v_q, v_d;
  logic [ACC_W-1:0]             m2_q, m2_d;

  // output register
  logic             ovalid_q, ovalid_d;
  logic             oacc_q, oacc_d;
  logic             onewp_q, onewp_d;
  logic [VAL_W-1:0] ovwap_q, ovwap_d;
  logic [VAL_W-1:0] odev_q, odev_d;
  logic [BW-1:0]    olo_q [vwap_pkg::MAX_BANDS];
  logic [BW-1:0]    olo_d [vwap_pkg::MAX_BANDS];
  logic [BW-1:0]    ohi_q [vwap_pkg::MAX_BANDS];
  logic [BW-1:0]    ohi_d [vwap_pkg::MAX_BANDS];
  logic             oovf_q, oovf_d;
  logic             ozero_q, ozero_d;

  // ---- shared units -------------------------------------------------------
  logic                         div_start;
  logic [vwap_pkg::DVD_W-1:0]   div_dvd;
  logic [ACC_W-1:0]             div_den;
  logic                         div_busy;
  logic                         div_done;
  logic [vwap_pkg::DVD_W-1:0]   div_quot;
  logic [ACC_W-1:0]             div_rem;
  logic                         sq_start;
  logic [ACC_W-1:0]             sq_val;
  logic                         sq_done;
  logic [vwap_pkg::ROOT_W-1:0]  sq_root;
  logic [vwap_pkg::MUL_A_W-1:0] mul_a;
  logic [vwap_pkg::MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]             mul_p;

  vwap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  vwap_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign mul_p = mul_a * mul_b;

  function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
                                             input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[ACC_W]) begin
      s = {1'b1, {ACC_W{1'b1}}};
    end
    return s;
  endfunction

  logic [OPN_W:0]   period_end_at;
  logic [PER_W:0]   win_hi;
  logic             in_session;
  logic [ACC_W:0]   add_pv;
  logic [ACC_W:0]   add_v;
  logic [ACC_W:0]   add_sq;
  logic [BW-1:0]    kdev [vwap_pkg::MAX_BANDS];
  logic [vwap_pkg::CNT_W-1:0] nb;

  always_comb begin
    period_end_at = {1'b0, open_q} + {{(OPN_W+1-PER_W){1'b0}}, per_eff};
    win_hi        = {{(PER_W+1-OFS_W){1'b0}}, offset_q} + dur_eff;
    in_session    = !daily ||
                    ((div_rem >= {{(ACC_W-OFS_W){1'b0}}, offset_q}) &&
                     (div_rem <  {{(ACC_W-PER_W-1){1'b0}}, win_hi}));
    add_pv = sat_add(spv_q, prod_q);
    add_v  = sat_add(sv_q, {{(ACC_W-vwap_pkg::VOL_W){1'b0}}, vol_q});
    add_sq = sat_add(spsv_q, prod_q);
    nb     = (bands_q > vwap_pkg::CNT_W'(vwap_pkg::MAX_BANDS))
             ? vwap_pkg::CNT_W'(vwap_pkg::MAX_BANDS) : bands_q;
    for (int i = 0; i < vwap_pkg::MAX_BANDS; i++) begin
      kdev[i] = BW'({{(BW-VAL_W){1'b0}}, hdev_q} * BW'(i + 1));
    end
  end

  // ---- sequencer -------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    ts_d      = ts_q;
    price_d   = price_q;
    vol_d     = vol_q;
    active_d  = active_q;
    open_d    = open_q;
    spv_d     = spv_q;
    sv_d      = sv_q;
    spsv_d    = spsv_q;
    hvwap_d   = hvwap_q;
    hdev_d    = hdev_q;
    ovf_d     = ovf_q;
    acc_d     = acc_q;
    newp_d    = newp_q;
    prod_d    = prod_q;
    v_d       = v_q;
    m2_d      = m2_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    oacc_d    = oacc_q;
    onewp_d   = onewp_q;
    ovwap_d   = ovwap_q;
    odev_d    = odev_q;
    olo_d     = olo_q;
    ohi_d     = ohi_q;
    oovf_d    = oovf_q;
    ozero_d   = ozero_q;
    div_start = 1'b0;
    div_dvd   = {{(vwap_pkg::DVD_W-TS_W){1'b0}}, ts_q};
    div_den   = {{(ACC_W-PER_W){1'b0}}, per_eff};
    sq_start  = 1'b0;
    sq_val    = (m2_q > prod_q) ? m2_q - prod_q : '0;
    mul_a     = {{(vwap_pkg::MUL_A_W-vwap_pkg::PRICE_W){1'b0}}, price_q};
    mul_b     = {{(vwap_pkg::MUL_B_W-vwap_pkg::VOL_W){1'b0}}, vol_q};
    in_i.ready = (state_q == vwap_pkg::S_IDLE);

    case (state_q)
      vwap_pkg::S_IDLE: begin
        if (in_i.valid) begin
          ts_d    = in_i.timestamp;
          price_d = in_i.price;
          vol_d   = in_i.volume;
          state_d = vwap_pkg::S_CHECK;
        end
      end
      vwap_pkg::S_CHECK: begin
        // period end is checked ahead of the session window
        if (active_q && ({2'b00, ts_q} >= period_end_at)) begin
          active_d = 1'b0;
          spv_d    = '0;
          sv_d     = '0;
          spsv_d   = '0;
          hvwap_d  = '0;
          hdev_d   = '0;
          ovf_d    = 1'b0;
        end
        div_start = 1'b1;
        state_d   = vwap_pkg::S_TS_DIV;
      end
      vwap_pkg::S_TS_DIV: begin
        if (div_done) begin
          acc_d  = in_session;
          newp_d = 1'b0;
          if (!in_session) begin
            state_d = vwap_pkg::S_OUT;
          end else begin
            if (!active_q) begin
              open_d   = OPN_W'({1'b0, ts_q} - {1'b0, div_rem[TS_W-1:0]}) +
                         (daily ? {{(OPN_W-OFS_W){1'b0}}, offset_q} : '0);
              active_d = 1'b1;
              newp_d   = 1'b1;
            end
            prod_d  = mul_p[ACC_W-1:0];
            state_d = vwap_pkg::S_MUL_PP;
          end
        end
      end
      vwap_pkg::S_MUL_PP: begin
        spv_d   = add_pv[ACC_W-1:0];
        sv_d    = add_v[ACC_W-1:0];
        ovf_d   = ovf_q || add_pv[ACC_W] || add_v[ACC_W];
        mul_b   = {{(vwap_pkg::MUL_B_W-vwap_pkg::PRICE_W){1'b0}}, price_q};
        prod_d  = mul_p[ACC_W-1:0];
        state_d = vwap_pkg::S_MUL_PPV;
      end
      vwap_pkg::S_MUL_PPV: begin
        mul_a   = prod_q[vwap_pkg::MUL_A_W-1:0];
        prod_d  = mul_p[ACC_W-1:0];
        state_d = vwap_pkg::S_ACC_SQ;
      end
      vwap_pkg::S_ACC_SQ: begin
        spsv_d = add_sq[ACC_W-1:0];
        ovf_d  = ovf_q || add_sq[ACC_W];
        if (sv_q == '0) begin
          hvwap_d = '0;
          hdev_d  = '0;
          state_d = vwap_pkg::S_OUT;
        end else begin
          div_start = 1'b1;
          div_dvd   = {{vwap_pkg::FRAC_W{1'b0}}, spv_q, {vwap_pkg::FRAC_W{1'b0}}};
          div_den   = sv_q;
          state_d   = vwap_pkg::S_DIV_V;
        end
      end
      vwap_pkg::S_DIV_V: begin
        div_dvd = {spsv_q, {(2*vwap_pkg::FRAC_W){1'b0}}};
        div_den = sv_q;
        if (div_done) begin
          v_d       = (div_quot[vwap_pkg::DVD_W-1:VAL_W] != '0) ? vwap_pkg::VAL_MAX
                                                               : div_quot[VAL_W-1:0];
          div_start = 1'b1;
          state_d   = vwap_pkg::S_DIV_M;
        end
      end
      vwap_pkg::S_DIV_M: begin
        if (div_done) begin
          m2_d    = (div_quot[vwap_pkg::DVD_W-1:ACC_W] != '0) ? {ACC_W{1'b1}}
                                                             : div_quot[ACC_W-1:0];
          state_d = vwap_pkg::S_MUL_VV;
        end
      end
      vwap_pkg::S_MUL_VV: begin
        mul_a   = {{(vwap_pkg::MUL_A_W-VAL_W){1'b0}}, v_q};
        mul_b   = v_q;
        prod_d  = mul_p[ACC_W-1:0];
        state_d = vwap_pkg::S_SQRT_GO;
      end
      vwap_pkg::S_SQRT_GO: begin
        sq_start = 1'b1;
        state_d  = vwap_pkg::S_SQRT;
      end
      vwap_pkg::S_SQRT: begin
        if (sq_done) begin
          hvwap_d = v_q;
          hdev_d  = (sq_root[vwap_pkg::ROOT_W-1:VAL_W] != '0) ? vwap_pkg::VAL_MAX
                                                             : sq_root[VAL_W-1:0];
          state_d = vwap_pkg::S_OUT;
        end
      end
      vwap_pkg::S_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          oacc_d   = acc_q;
          onewp_d  = newp_q;
          ovwap_d  = hvwap_q;
          odev_d   = hdev_q;
          oovf_d   = ovf_q;
          ozero_d  = (sv_q == '0);
          for (int i = 0; i < vwap_pkg::MAX_BANDS; i++) begin
            if ((i < int'(nb)) && (sv_q != '0)) begin
              olo_d[i] = {{(BW-VAL_W){1'b0}}, hvwap_q} - kdev[i];
              ohi_d[i] = {{(BW-VAL_W){1'b0}}, hvwap_q} + kdev[i];
            end else begin
              olo_d[i] = '0;
              ohi_d[i] = '0;
            end
          end
          state_d = vwap_pkg::S_IDLE;
        end
      end
      default: state_d = vwap_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vwap_pkg::S_IDLE;
      active_q <= 1'b0;
      open_q   <= '0;
      spv_q    <= '0;
      sv_q     <= '0;
      spsv_q   <= '0;
      hvwap_q  <= '0;
      hdev_q   <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      open_q   <= open_d;
      spv_q    <= spv_d;
      sv_q     <= sv_d;
      spsv_q   <= spsv_d;
      hvwap_q  <= hvwap_d;
      hdev_q   <= hdev_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q    <= ts_d;
    price_q <= price_d;
    vol_q   <= vol_d;
    acc_q   <= acc_d;
    newp_q  <= newp_d;
    prod_q  <= prod_d;
    v_q     <= v_d;
    m2_q    <= m2_d;
    oacc_q  <= oacc_d;
    onewp_q <= onewp_d;
    ovwap_q <= ovwap_d;
    odev_q  <= odev_d;
    olo_q   <= olo_d;
    ohi_q   <= ohi_d;
    oovf_q  <= oovf_d;
    ozero_q <= ozero_d;
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.accepted    = oacc_q;
  assign out_o.new_period  = onewp_q;
  assign out_o.vwap        = ovwap_q;
  assign out_o.std_dev     = odev_q;
  assign out_o.band1_low   = olo_q[0];
  assign out_o.band1_high  = ohi_q[0];
  assign out_o.band2_low   = olo_q[1];
  assign out_o.band2_high  = ohi_q[1];
  assign out_o.band3_low   = olo_q[2];
  assign out_o.band3_high  = ohi_q[2];
  assign out_o.overflow    = oovf_q;
  assign out_o.zero_volume = ozero_q;

`ifndef SYNTHESIS
  // divider is only restarted once its previous run has finished
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_zero_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.zero_volume) |->
      (out_o.vwap == '0 && out_o.std_dev == '0 && out_o.band1_low == '0))
    else $error("zero volume with non-zero outputs");

  a_newp_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.new_period) |-> out_o.accepted)
    else $error("new period flagged on a rejected trade");
`endif

endmodule

[test/tb_vwap_with_deviation_bands.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vwap_with_deviation_bands
// Self-checking bench: random and directed trade requests, a cycle-free
// predictor of the per-period VWAP and deviation bands, APB register phases.
// ----------------------------------------------------------------------------
module tb_vwap_with_deviation_bands;

  typedef struct packed {
    logic [vwap_pkg::TS_W-1:0]    ts;
    logic [vwap_pkg::PRICE_W-1:0] price;
    logic [vwap_pkg::VOL_W-1:0]   vol;
  } trade_t;

  typedef struct packed {
    logic                        accepted;
    logic                        new_period;
    logic [vwap_pkg::VAL_W-1:0]  vwap;
    logic [vwap_pkg::VAL_W-1:0]  std_dev;
    logic [vwap_pkg::BAND_W-1:0] b1l, b1h, b2l, b2h, b3l, b3h;
    logic                        overflow;
    logic                        zero_volume;
  } quote_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [vwap_pkg::APB_AW-1:0] paddr = '0;
  logic [vwap_pkg::APB_DW-1:0] pwdata = '0;
  logic [vwap_pkg::APB_DW-1:0] prdata;
  logic pready;

  vwap_in_if  trade_if ();
  vwap_out_if quote_if ();

  vwap_with_deviation_bands DUT (
    .clk_i, .rst_ni, .in_i(trade_if.sink), .out_o(quote_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // predictor state and configuration
  logic [31:0] per_cfg;
  logic        filt_cfg;
  logic [16:0] ofs_cfg, dur_cfg;
  logic [1:0]  bands_cfg;
  bit          active, ovf;
  logic [63:0] open_t, spv, sv, spsv;
  logic [63:0] hvwap, hdev;

  trade_t pending_trades[$];
  quote_t expected_quotes[$];
  int     errors = 0;
  bit     idle_on = 1'b1;
  int     hold_off = 0;
  int     src_gap = 0;
  bit     in_taken = 1'b0;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      ovf = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    if (p[127:64] != 0) begin
      ovf = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den, int fb,
                                           logic [63:0] cap);
    logic [127:0] q;
    q = ({64'd0, num} << fb) / {64'd0, den};
    return (q > {64'd0, cap}) ? cap : q[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= {64'd0, v}) r = t;
    end
    return r;
  endfunction

  task automatic clear_period();
    active = 0; spv = 0; sv = 0; spsv = 0; hvwap = 0; hdev = 0; ovf = 0;
  endtask

  task automatic predict_quote(trade_t t);
    logic [63:0] ts, per, dur, start, pv, m2, vv, s;
    logic signed [63:0] d;
    bit daily, acc, np;
    quote_t q;
    logic [vwap_pkg::BAND_W-1:0] lo[3], hi[3];
    ts = t.ts;
    per = (per_cfg != 0) ? per_cfg : 1;
    daily = filt_cfg && per == 86400;
    acc = 1; np = 0;
    if (active && ts >= open_t + per) clear_period();
    if (daily) begin
      dur = (dur_cfg != 0) ? dur_cfg : per;
      start = ts - ts % 86400 + ofs_cfg;
      if (ts < start || ts >= start + dur) acc = 0;
    end
    if (acc) begin
      if (!active) begin
        open_t = ts - ts % per;
        if (daily) open_t += ofs_cfg;
        active = 1; np = 1;
      end
      spv = add_sat(spv, mul_sat(t.price, t.vol));
      sv = add_sat(sv, t.vol);
      spsv = add_sat(spsv, mul_sat(mul_sat(t.price, t.price), t.vol));
      if (sv != 0) begin
        pv = frac_div(spv, sv, vwap_pkg::FRAC_W, vwap_pkg::VAL_MAX);
        m2 = frac_div(spsv, sv, 2 * vwap_pkg::FRAC_W, '1);
        vv = pv * pv;
        s = root64(m2 > vv ? m2 - vv : 0);
        hvwap = pv;
        hdev = (s > vwap_pkg::VAL_MAX) ? vwap_pkg::VAL_MAX : s;
      end else begin
        hvwap = 0; hdev = 0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      lo[k] = 0; hi[k] = 0;
      if (k < bands_cfg && sv != 0) begin
        d = $signed(hdev) * (k + 1);
        lo[k] = vwap_pkg::BAND_W'($signed(hvwap) - d);
        hi[k] = vwap_pkg::BAND_W'($signed(hvwap) + d);
      end
    end
    q.accepted = acc; q.new_period = np;
    q.vwap = hvwap[vwap_pkg::VAL_W-1:0]; q.std_dev = hdev[vwap_pkg::VAL_W-1:0];
    q.b1l = lo[0]; q.b1h = hi[0]; q.b2l = lo[1]; q.b2h = hi[1];
    q.b3l = lo[2]; q.b3h = hi[2];
    q.overflow = ovf; q.zero_volume = (sv == 0);
    expected_quotes = {expected_quotes, q};
  endtask

  // driver
  initial begin
    trade_if.valid = 1'b0;
    trade_if.timestamp = '0; trade_if.price = '0; trade_if.volume = '0;
  end

  // request taken at this edge: predict it and let the driver move on
  always @(posedge clk_i) begin
    in_taken <= rst_ni && trade_if.valid && trade_if.ready;
    if (rst_ni && trade_if.valid && trade_if.ready) begin
      predict_quote({trade_if.timestamp, trade_if.price, trade_if.volume});
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!trade_if.valid || in_taken) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          trade_if.valid <= 1'b0;
        end else if (pending_trades.size() != 0 &&
                     !(idle_on && $urandom_range(0, 7) == 0)) begin
          trade_t t;
          t = pending_trades[0];
          pending_trades.delete(0);
          trade_if.valid <= 1'b1;
          trade_if.timestamp <= t.ts;
          trade_if.price <= t.price;
          trade_if.volume <= t.vol;
        end else begin
          trade_if.valid <= 1'b0;
          if (idle_on && pending_trades.size() != 0) src_gap <= $urandom_range(0, 9);
        end
      end
    end
  end

  // sink stall bursts
  int stall_left = 0;
  initial quote_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      quote_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      quote_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      quote_if.ready <= 1'b0;
    end else begin
      quote_if.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && quote_if.valid && quote_if.ready) begin
      quote_t g, e;
      g = {quote_if.accepted, quote_if.new_period, quote_if.vwap, quote_if.std_dev,
           quote_if.band1_low, quote_if.band1_high, quote_if.band2_low,
           quote_if.band2_high, quote_if.band3_low, quote_if.band3_high,
           quote_if.overflow, quote_if.zero_volume};
      if (expected_quotes.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_quotes[0];
        expected_quotes.delete(0);
        if (g.accepted !== e.accepted) begin
          $error("accepted exp %0d got %0d", e.accepted, g.accepted); errors++; end
        if (g.new_period !== e.new_period) begin
          $error("new_period exp %0d got %0d", e.new_period, g.new_period); errors++; end
        if (g.vwap !== e.vwap) begin
          $error("vwap exp %0h got %0h", e.vwap, g.vwap); errors++; end
        if (g.std_dev !== e.std_dev) begin
          $error("std_dev exp %0h got %0h", e.std_dev, g.std_dev); errors++; end
        if (g.b1l !== e.b1l) begin
          $error("band1_low exp %0h got %0h", e.b1l, g.b1l); errors++; end
        if (g.b1h !== e.b1h) begin
          $error("band1_high exp %0h got %0h", e.b1h, g.b1h); errors++; end
        if (g.b2l !== e.b2l) begin
          $error("band2_low exp %0h got %0h", e.b2l, g.b2l); errors++; end
        if (g.b2h !== e.b2h) begin
          $error("band2_high exp %0h got %0h", e.b2h, g.b2h); errors++; end
        if (g.b3l !== e.b3l) begin
          $error("band3_low exp %0h got %0h", e.b3l, g.b3l); errors++; end
        if (g.b3h !== e.b3h) begin
          $error("band3_high exp %0h got %0h", e.b3h, g.b3h); errors++; end
        if (g.overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, g.overflow); errors++; end
        if (g.zero_volume !== e.zero_volume) begin
          $error("zero_volume exp %0d got %0d", e.zero_volume, g.zero_volume); errors++; end
      end
    end
  end

  task automatic reg_write(vwap_pkg::cfg_reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= vwap_pkg::APB_AW'(4 * r); pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      vwap_pkg::REG_PERIOD:   per_cfg = v;
      vwap_pkg::REG_FILTER:   filt_cfg = v[0];
      vwap_pkg::REG_OFFSET:   ofs_cfg = v[16:0];
      vwap_pkg::REG_DURATION: dur_cfg = v[16:0];
      vwap_pkg::REG_BANDS:    bands_cfg = v[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_trades.size() != 0 || trade_if.valid || expected_quotes.size() != 0)
      @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic add_trade(longint unsigned ts, int unsigned p, int unsigned v);
    trade_t t;
    t.ts = vwap_pkg::TS_W'(ts);
    t.price = vwap_pkg::PRICE_W'(p);
    t.vol = vwap_pkg::VOL_W'(v);
    pending_trades = {pending_trades, t};
  endtask

  // mostly increasing time within a few periods, sometimes wild values
  logic [39:0] clock_s;
  task automatic random_trades(int n, int step_max);
    for (int i = 0; i < n; i++) begin
      logic [39:0] ts;
      logic [19:0] p;
      logic [15:0] v;
      clock_s += $urandom_range(0, step_max);
      ts = clock_s;
      p = vwap_pkg::PRICE_W'($urandom_range(400, 600));
      v = vwap_pkg::VOL_W'($urandom_range(1, 2000));
      case ($urandom_range(0, 9))
        0: p = vwap_pkg::PRICE_W'($urandom());
        1: v = vwap_pkg::VOL_W'($urandom());
        2: v = 0;
        3: ts = vwap_pkg::TS_W'({$urandom(), $urandom()});
        4: begin p = '1; v = '1; end
        default: ;
      endcase
      add_trade(ts, p, v);
    end
  endtask

  initial begin
    per_cfg = 86400; filt_cfg = 0; ofs_cfg = 0; dur_cfg = 0; bands_cfg = 3;
    open_t = 0;
    clear_period();
    clock_s = 40'd1000000;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, zero volume, saturation, period roll
    add_trade(0, 0, 0);
    add_trade(1, '1, '1);
    add_trade(2, '1, '1);
    for (int i = 0; i < 6; i++) add_trade(3, '1, '1);
    add_trade(86400, 100, 5);
    add_trade(86401, 0, 0);
    add_trade(86402, 300, 7);
    add_trade('1, '1, 1);
    add_trade('1, 0, '1);
    drain();
    reg_write(vwap_pkg::REG_PERIOD, 60);
    reg_write(vwap_pkg::REG_BANDS, 0);
    add_trade(120, 10, 1); add_trade(179, 20, 1); add_trade(180, 30, 3);
    drain();
    reg_write(vwap_pkg::REG_PERIOD, 0);
    reg_write(vwap_pkg::REG_BANDS, 1);
    add_trade(5, 7, 2); add_trade(5, 9, 2); add_trade(6, 7, 2);
    drain();
    // session filter, window crossing midnight and oversized offset
    reg_write(vwap_pkg::REG_PERIOD, 86400);
    reg_write(vwap_pkg::REG_FILTER, 1);
    reg_write(vwap_pkg::REG_OFFSET, 86399);
    reg_write(vwap_pkg::REG_DURATION, 86400);
    reg_write(vwap_pkg::REG_BANDS, 2);
    add_trade(86399, 50, 3); add_trade(86398, 50, 3); add_trade(86400 + 86399, 60, 4);
    drain();
    reg_write(vwap_pkg::REG_OFFSET, 17'h1FFFF);
    reg_write(vwap_pkg::REG_DURATION, 0);
    add_trade(86400 * 3 + 10, 5, 5);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin reg_write(vwap_pkg::REG_FILTER, 0); reg_write(vwap_pkg::REG_PERIOD, 300); end
        1: begin reg_write(vwap_pkg::REG_PERIOD, '1); reg_write(vwap_pkg::REG_BANDS, 3); end
        2: begin reg_write(vwap_pkg::REG_PERIOD, 86400); reg_write(vwap_pkg::REG_FILTER, 1);
                 reg_write(vwap_pkg::REG_OFFSET, 3600);
                 reg_write(vwap_pkg::REG_DURATION, 7200); end
        3: begin reg_write(vwap_pkg::REG_OFFSET, 0); reg_write(vwap_pkg::REG_DURATION, 0);
                 reg_write(vwap_pkg::REG_BANDS, 2); end
        4: begin reg_write(vwap_pkg::REG_FILTER, 0); reg_write(vwap_pkg::REG_PERIOD, 1); end
        5: begin reg_write(vwap_pkg::REG_PERIOD, $urandom_range(1, 5000));
                 reg_write(vwap_pkg::REG_BANDS, $urandom_range(0, 3)); end
        6: begin reg_write(vwap_pkg::REG_PERIOD, 86400); reg_write(vwap_pkg::REG_FILTER, 1);
                 reg_write(vwap_pkg::REG_OFFSET, $urandom_range(0, 86399));
                 reg_write(vwap_pkg::REG_DURATION, $urandom_range(1, 86400)); end
        default: begin reg_write(vwap_pkg::REG_FILTER, $urandom_range(0, 1));
                 reg_write(vwap_pkg::REG_BANDS, 3); idle_on = 1'b0; end
      endcase
      if (ph == 1) begin
        random_trades(20, 50);
        hold_off = 3000;
      end
      random_trades(150, (ph == 2 || ph == 6) ? 2000 : 40);
      drain();
    end

    if (errors == 0) begin
      $display("tb_vwap_with_deviation_bands: clean");
    end else begin
      $display("tb_vwap_with_deviation_bands: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_vwap_with_deviation_bands: errors");
    $finish;
  end

endmodule
